### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL that carries concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VAT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define VAT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg
// Constants, codes and controller/datapath interface types of the vertex
// affine transform.
// ----------------------------------------------------------------------------
package vat_pkg;

   localparam int COORD_W      = 32;
   localparam int COEF_W       = 16;
   localparam int OP_W         = 4;
   localparam int FRAC_W       = 16;
   localparam int MAX_VERTICES = 1048576;
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W        = COORD_W + $clog2(MAX_VERTICES);
   localparam int DIVD_W       = SUM_W - FRAC_W;
   localparam int ITER_W       = $clog2(DIVD_W);
   localparam int PROD_W       = 2 * COORD_W;
   localparam int ROT_SHIFT    = 14;
   localparam int SCALE_SHIFT  = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_MOVE_X = 4'd0;
   localparam logic [OP_W-1:0] OP_MOVE_Y = 4'd1;
   localparam logic [OP_W-1:0] OP_MOVE_Z = 4'd2;
   localparam logic [OP_W-1:0] OP_ROT_X  = 4'd3;
   localparam logic [OP_W-1:0] OP_ROT_Y  = 4'd4;
   localparam logic [OP_W-1:0] OP_ROT_Z  = 4'd5;
   localparam logic [OP_W-1:0] OP_SCALE  = 4'd6;
   localparam logic [OP_W-1:0] OP_ACCUM  = 4'd7;
   localparam logic [OP_W-1:0] OP_CENTRE = 4'd8;

   // register indexes
   localparam logic [2:0] REG_OPERATION = 3'd0;
   localparam logic [2:0] REG_OFFSET    = 3'd1;
   localparam logic [2:0] REG_COS       = 3'd2;
   localparam logic [2:0] REG_SIN       = 3'd3;
   localparam logic [2:0] REG_SCALE     = 3'd4;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef logic [1:0] coef_type;
   localparam coef_type COEF_COS   = 2'd0;
   localparam coef_type COEF_SIN   = 2'd1;
   localparam coef_type COEF_NSIN  = 2'd2;
   localparam coef_type COEF_SCALE = 2'd3;

   typedef struct packed {
      logic     load_in;
      logic     simple;
      logic     mul_en;
      logic     acc_en;
      logic     acc_clear;
      logic     rnd_en;
      logic     rnd_rot;
      axis_type coord_sel;
      coef_type coef_sel;
      axis_type dst_sel;
      logic     div_load;
      logic     div_step;
      logic     div_store;
      axis_type div_axis;
      logic     mean_clear;
      logic     out_load;
   } vat_cmd_type;

   typedef struct packed {
      logic first;
      logic count_zero;
      logic scale_zero;
   } vat_sts_type;

endpackage

### hw/rtl/vat_ctrl.sv
// ----------------------------------------------------------------------------
// vat_ctrl
// Sequencer: steps the datapath through load, multiply/accumulate/round,
// mean division and result hand-off, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module vat_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [vat_pkg::OP_W-1:0]      operation,
   input  vat_pkg::vat_sts_type          sts,
   output vat_pkg::vat_cmd_type          cmd
);
   import vat_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_START     = 4'd1;
   localparam logic [3:0] S_MUL       = 4'd2;
   localparam logic [3:0] S_ACC       = 4'd3;
   localparam logic [3:0] S_RND       = 4'd4;
   localparam logic [3:0] S_DIV_LOAD  = 4'd5;
   localparam logic [3:0] S_DIV_STEP  = 4'd6;
   localparam logic [3:0] S_DIV_STORE = 4'd7;
   localparam logic [3:0] S_SIMPLE    = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        term_ff, term_in;
   axis_type          axis_ff, axis_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic     is_rot;
   axis_type axis_a, axis_b;
   axis_type coord_sel, dst_sel;
   coef_type coef_sel;
   logic     term_first, term_last, term_final;
   logic     out_free;

   // term decode: rotation uses four products, two per output axis
   always_comb begin
      is_rot = 1'b0;
      axis_a = AXIS_X;
      axis_b = AXIS_Y;
      unique case (operation)
         OP_ROT_X: begin
            is_rot = 1'b1;
            axis_a = AXIS_Y;
            axis_b = AXIS_Z;
         end
         OP_ROT_Y: begin
            is_rot = 1'b1;
            axis_a = AXIS_Z;
            axis_b = AXIS_X;
         end
         OP_ROT_Z: begin
            is_rot = 1'b1;
            axis_a = AXIS_X;
            axis_b = AXIS_Y;
         end
         default: ;
      endcase
      if (is_rot) begin
         coord_sel  = term_ff[0] ? axis_b : axis_a;
         dst_sel    = term_ff[1] ? axis_b : axis_a;
         term_first = ~term_ff[0];
         term_last  = term_ff[0];
         term_final = (term_ff == 2'd3);
         unique case (term_ff)
            2'd0:    coef_sel = COEF_COS;
            2'd1:    coef_sel = COEF_NSIN;
            2'd2:    coef_sel = COEF_SIN;
            default: coef_sel = COEF_COS;
         endcase
      end else begin
         // scale: one product per axis, term number is the axis
         coord_sel  = term_ff;
         dst_sel    = term_ff;
         coef_sel   = COEF_SCALE;
         term_first = 1'b1;
         term_last  = 1'b1;
         term_final = (term_ff == AXIS_Z);
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      axis_in      = axis_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.coord_sel = coord_sel;
      cmd.coef_sel  = coef_sel;
      cmd.dst_sel   = dst_sel;
      cmd.acc_clear = term_first;
      cmd.rnd_rot   = is_rot;
      cmd.div_axis  = axis_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            term_in = 2'd0;
            axis_in = AXIS_X;
            if (is_rot || (operation == OP_SCALE && !sts.scale_zero)) begin
               state_in = S_MUL;
            end else if (operation == OP_CENTRE && sts.first) begin
               if (sts.count_zero) begin
                  cmd.mean_clear = 1'b1;
                  state_in       = S_SIMPLE;
               end else begin
                  state_in = S_DIV_LOAD;
               end
            end else begin
               state_in = S_SIMPLE;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            if (term_last) begin
               state_in = S_RND;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_RND: begin
            cmd.rnd_en = 1'b1;
            if (term_final) begin
               state_in = S_FINISH;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            iter_in      = '0;
            state_in     = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(DIVD_W - 1)) begin
               state_in = S_DIV_STORE;
            end
         end
         S_DIV_STORE: begin
            cmd.div_store = 1'b1;
            if (axis_ff == AXIS_Z) begin
               state_in = S_SIMPLE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_DIV_LOAD;
            end
         end
         S_SIMPLE: begin
            cmd.simple = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         term_ff      <= '0;
         axis_ff      <= AXIS_X;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         axis_ff      <= axis_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### hw/rtl/vat_dp.sv
// ----------------------------------------------------------------------------
// vat_dp
// Datapath: vertex and result registers, shared 32x32 multiplier with
// accumulator and rounding, running sums, bit-serial mean divider, output
// register.
// ----------------------------------------------------------------------------
module vat_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  vat_pkg::vat_cmd_type                cmd,
   output vat_pkg::vat_sts_type                sts,
   input  logic [vat_pkg::OP_W-1:0]            operation,
   input  logic signed [vat_pkg::COORD_W-1:0]  offset,
   input  logic signed [vat_pkg::COEF_W-1:0]   cos_value,
   input  logic signed [vat_pkg::COEF_W-1:0]   sin_value,
   input  logic signed [vat_pkg::COORD_W-1:0]  scale_factor,
   input  logic signed [vat_pkg::COORD_W-1:0]  coord_x,
   input  logic signed [vat_pkg::COORD_W-1:0]  coord_y,
   input  logic signed [vat_pkg::COORD_W-1:0]  coord_z,
   input  logic                                first_of_pass,
   output logic signed [vat_pkg::COORD_W-1:0]  out_x,
   output logic signed [vat_pkg::COORD_W-1:0]  out_y,
   output logic signed [vat_pkg::COORD_W-1:0]  out_z
);
   import vat_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_ROT   = PROD_W'(1) << (ROT_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] HALF_SCALE = PROD_W'(1) << (SCALE_SHIFT - 1);

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [PROD_W-1:0] v
   );
      logic [PROD_W-COORD_W:0] top;
      top = v[PROD_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
         return v[COORD_W-1:0];
      end else if (v[PROD_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   logic signed [COORD_W-1:0] in_ff   [3];
   logic signed [COORD_W-1:0] in_in   [3];
   logic signed [COORD_W-1:0] res_ff  [3];
   logic signed [COORD_W-1:0] res_in  [3];
   logic signed [COORD_W-1:0] outr_ff [3];
   logic signed [COORD_W-1:0] outr_in [3];
   logic signed [COORD_W-1:0] mean_ff [3];
   logic signed [COORD_W-1:0] mean_in [3];
   logic signed [SUM_W-1:0]   sum_ff  [3];
   logic signed [SUM_W-1:0]   sum_in  [3];
   logic                      first_ff, first_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic [DIVD_W-1:0]         dvd_ff, dvd_in;
   logic [COUNT_W-1:0]        rem_ff, rem_in;
   logic                      neg_ff, neg_in;

   logic signed [COORD_W-1:0] coef;
   logic signed [PROD_W-1:0]  rnd_add;
   logic signed [PROD_W-1:0]  rnd_shift;
   logic signed [COORD_W-1:0] rnd_sat;
   logic [COUNT_W-1:0]        count_base;
   logic signed [SUM_W-1:0]   div_sum;
   logic [SUM_W-1:0]          div_mag;
   logic [COUNT_W:0]          div_shifted;
   logic [COUNT_W+1:0]        div_diff;
   logic [COORD_W-1:0]        mean_mag;

   always_comb begin
      case (cmd.coef_sel)
         COEF_COS:  coef = COORD_W'(cos_value);
         COEF_SIN:  coef = COORD_W'(sin_value);
         COEF_NSIN: coef = -COORD_W'(sin_value);
         default:   coef = scale_factor;
      endcase
   end

   // round to nearest, ties up, then saturate
   always_comb begin
      rnd_add   = acc_ff + (cmd.rnd_rot ? HALF_ROT : HALF_SCALE);
      rnd_shift = cmd.rnd_rot ? (rnd_add >>> ROT_SHIFT) : (rnd_add >>> SCALE_SHIFT);
      rnd_sat   = sat_coord(rnd_shift);
   end

   // mean divider: |sum| / 2^16 divided by the count, one quotient bit a cycle
   always_comb begin
      div_sum     = sum_ff[cmd.div_axis];
      div_mag     = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
      div_shifted = {rem_ff, dvd_ff[DIVD_W-1]};
      div_diff    = {1'b0, div_shifted} - (COUNT_W+2)'(count_ff);
      mean_mag    = {dvd_ff[COORD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
   end

   assign count_base = first_ff ? '0 : count_ff;

   always_comb begin
      in_in    = in_ff;
      first_in = first_ff;
      res_in   = res_ff;
      outr_in  = outr_ff;
      mean_in  = mean_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;

      if (cmd.load_in) begin
         in_in[0] = coord_x;
         in_in[1] = coord_y;
         in_in[2] = coord_z;
         res_in   = '{coord_x, coord_y, coord_z};
         first_in = first_of_pass;
      end

      if (cmd.mul_en) begin
         prod_in = in_ff[cmd.coord_sel] * coef;
      end

      if (cmd.acc_en) begin
         acc_in = cmd.acc_clear ? prod_ff : acc_ff + prod_ff;
      end

      if (cmd.rnd_en) begin
         res_in[cmd.dst_sel] = rnd_sat;
      end

      if (cmd.simple) begin
         for (int i = 0; i < 3; i++) begin
            case (operation) inside
               OP_MOVE_X, OP_MOVE_Y, OP_MOVE_Z: begin
                  if (operation[1:0] == 2'(i)) begin
                     res_in[i] = sat_coord(PROD_W'(in_ff[i]) + PROD_W'(offset));
                  end
               end
               OP_CENTRE: begin
                  res_in[i] = sat_coord(PROD_W'(in_ff[i]) - PROD_W'(mean_ff[i]));
               end
               OP_ACCUM: begin
                  if (count_base < COUNT_W'(MAX_VERTICES)) begin
                     sum_in[i] = (first_ff ? '0 : sum_ff[i]) + SUM_W'(in_ff[i]);
                  end
               end
               default: ;
            endcase
         end
         if (operation == OP_ACCUM) begin
            if (count_base < COUNT_W'(MAX_VERTICES)) begin
               count_in = count_base + COUNT_W'(1);
            end
         end
      end

      if (cmd.div_load) begin
         dvd_in = div_mag[SUM_W-1:FRAC_W];
         rem_in = '0;
         neg_in = div_sum[SUM_W-1];
      end

      if (cmd.div_step) begin
         if (!div_diff[COUNT_W+1]) begin
            rem_in = div_diff[COUNT_W-1:0];
            dvd_in = {dvd_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = div_shifted[COUNT_W-1:0];
            dvd_in = {dvd_ff[DIVD_W-2:0], 1'b0};
         end
      end

      if (cmd.div_store) begin
         mean_in[cmd.div_axis] = neg_ff ? -mean_mag : mean_mag;
      end

      if (cmd.mean_clear) begin
         mean_in = '{default: '0};
      end

      if (cmd.out_load) begin
         outr_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '{default: '0};
         mean_ff  <= '{default: '0};
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         mean_ff  <= mean_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff    <= in_in;
      first_ff <= first_in;
      res_ff   <= res_in;
      outr_ff  <= outr_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
   end

   assign sts.first      = first_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.scale_zero = (scale_factor == '0);

   assign out_x = outr_ff[0];
   assign out_y = outr_ff[1];
   assign out_z = outr_ff[2];

endmodule

### hw/rtl/vertex_affine_transform.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform
// Per-vertex translate, rotate, scale and centring with saturated Q16.16
// results; register file on an APB-style port.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | tdata: coord_x, coord_y, coord_z; tuser: first_of_pass
//  rsp_    | out       | tdata: out_x, out_y, out_z
//  csr_    | in/out    | operation, offset, cos_value, sin_value, scale_factor
//
//  Move, accumulate, centre, zero-factor scale and unused codes take the
//  simple path; scale and rotation use the one shared 32x32 multiplier, with
//  a multiply and an accumulate step per product and a round step per axis.
//  The first vertex of a centre pass with a non-zero count also runs the
//  bit-serial mean divider once per axis.
//  Reset is synchronous; sums, count and means clear to zero.
//  A finished result waits in the output register; the next vertex is taken
//  meanwhile and its result is held until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_affine_transform (
   input  logic         clock,
   input  logic         reset,
   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
   input  logic [95:0]  req_tdata,
   // first_of_pass [0]
   input  logic         req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // out_x [31:0], out_y [63:32], out_z [95:64]
   output logic [95:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import vat_pkg::*;

   logic [OP_W-1:0]           operation_ff, operation_in;
   logic signed [COORD_W-1:0] offset_ff, offset_in;
   logic signed [COEF_W-1:0]  cos_value_ff, cos_value_in;
   logic signed [COEF_W-1:0]  sin_value_ff, sin_value_in;
   logic signed [COORD_W-1:0] scale_factor_ff, scale_factor_in;

   logic        csr_wr;
   logic [2:0]  csr_index;
   vat_cmd_type cmd;
   vat_sts_type sts;
   logic signed [COORD_W-1:0] out_x, out_y, out_z;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      operation_in    = operation_ff;
      offset_in       = offset_ff;
      cos_value_in    = cos_value_ff;
      sin_value_in    = sin_value_ff;
      scale_factor_in = scale_factor_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_OPERATION: operation_in    = csr_pwdata[OP_W-1:0];
            REG_OFFSET:    offset_in       = csr_pwdata;
            REG_COS:       cos_value_in    = csr_pwdata[COEF_W-1:0];
            REG_SIN:       sin_value_in    = csr_pwdata[COEF_W-1:0];
            REG_SCALE:     scale_factor_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_OPERATION: csr_prdata = 32'(operation_ff);
         REG_OFFSET:    csr_prdata = offset_ff;
         REG_COS:       csr_prdata = 32'(cos_value_ff);
         REG_SIN:       csr_prdata = 32'(sin_value_ff);
         REG_SCALE:     csr_prdata = scale_factor_ff;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff    <= OP_MOVE_X;
         offset_ff       <= '0;
         cos_value_ff    <= COEF_W'(16384);
         sin_value_ff    <= '0;
         scale_factor_ff <= COORD_W'(65536);
      end else begin
         operation_ff    <= operation_in;
         offset_ff       <= offset_in;
         cos_value_ff    <= cos_value_in;
         sin_value_ff    <= sin_value_in;
         scale_factor_ff <= scale_factor_in;
      end
   end

   vat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .operation  (operation_ff),
      .sts        (sts),
      .cmd        (cmd)
   );

   vat_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .operation     (operation_ff),
      .offset        (offset_ff),
      .cos_value     (cos_value_ff),
      .sin_value     (sin_value_ff),
      .scale_factor  (scale_factor_ff),
      .coord_x       (req_tdata[31:0]),
      .coord_y       (req_tdata[63:32]),
      .coord_z       (req_tdata[95:64]),
      .first_of_pass (req_tuser),
      .out_x         (out_x),
      .out_y         (out_y),
      .out_z         (out_z)
   );

   assign rsp_tdata = {out_z, out_y, out_x};

   // one vertex in flight: no second transfer right after an accepted one
   `VAT_ASSERT_NXT(a_single_item, clock, reset, req_tvalid && req_tready, !req_tready)
   // a result is only loaded when the output register is free
   `VAT_ASSERT_IMP(a_out_free, clock, reset, cmd.out_load, !rsp_tvalid || rsp_tready)
   // means are only rewritten by a centre pass
   `VAT_ASSERT_IMP(a_mean_centre, clock, reset, cmd.div_store || cmd.mean_clear,
                   operation_ff == OP_CENTRE)

endmodule
